[hdl/tmcw_pkg.sv]
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int CHAR_W       = 8;
    localparam int CELL_W       = 16;
    localparam int CELL_INDEX_W = 11;
    localparam int ROW_W        = 5;
    localparam int COL_W        = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE       = 8'd32;
    localparam logic [CELL_W-1:0] RESET_CELL       = 16'h0720;
    localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'd7;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [1:0] t_op;
    localparam t_op OP_CHAR    = 2'd0;
    localparam t_op OP_NEWLINE = 2'd1;
    localparam t_op OP_READ    = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        t_op                     op;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_cmd;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } t_out_item;

endpackage

[hdl/tmcw_front.sv]
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts input transactions, decodes them into commands and buffers them
// in a short queue for the execution side.
// ----------------------------------------------------------------------------
module tmcw_front import tmcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    localparam logic [QPTR_W:0] FULL_CNT = (QPTR_W+1)'(QUEUE_DEPTH);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_cnt, n_cnt;
    t_cmd              dec_cmd;
    logic              push, pop;

    always_comb begin
        dec_cmd.char_code  = i_in_item.char_code;
        dec_cmd.cell_index = i_in_item.cell_index;
        if (i_in_item.req_type == REQ_READ) begin
            dec_cmd.op = OP_READ;
        end else if (i_in_item.char_code == NEWLINE_CODE) begin
            dec_cmd.op = OP_NEWLINE;
        end else begin
            dec_cmd.op = OP_CHAR;
        end
    end

    assign o_in_stall  = (r_cnt == FULL_CNT);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];
    assign push        = i_in_valid & ~o_in_stall;
    assign pop         = o_cmd_valid & i_cmd_ready;

    always_comb begin
        n_wptr = push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr = pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= dec_cmd;
        end
    end

endmodule

[hdl/tmcw_back.sv]
// ----------------------------------------------------------------------------
// tmcw_back
// Executes console commands against the screen store: cell writes, cursor
// movement, scrolling by row rotation with a bottom-row fill, cell reads.
// ----------------------------------------------------------------------------
module tmcw_back import tmcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CHAR_W-1:0] i_text_color,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    localparam int N  = ROWS * COLUMNS;
    localparam int AW = $clog2(N);
    localparam int SW = AW + 1;
    localparam int IW = ((AW > CELL_INDEX_W) ? AW : CELL_INDEX_W) + 1;

    localparam logic [SW-1:0]    N_S           = SW'(N);
    localparam logic [SW-1:0]    COL_S         = SW'(COLUMNS);
    localparam logic [IW-1:0]    N_I           = IW'(N);
    localparam logic [AW-1:0]    COL_A         = AW'(COLUMNS);
    localparam logic [AW-1:0]    ROW_SPAN      = AW'(COLUMNS - 1);
    localparam logic [AW-1:0]    LAST_ADDR     = AW'(N - 1);
    localparam logic [AW-1:0]    LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL      = COL_W'(COLUMNS - 1);

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [CELL_W-1:0] r_mem [N];
    logic [CELL_W-1:0] r_rd_data;

    logic [1:0]        r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [AW-1:0]     r_lin, n_lin;
    logic [AW-1:0]     r_row_base, n_row_base;
    logic [AW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [AW-1:0]     r_clr_end, n_clr_end;
    logic              r_rd_zero, n_rd_zero;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              out_free, cmd_take;
    logic [SW-1:0]     cur_sum, cur_wrap, rd_sum, rd_wrap, base_sum;
    logic [AW-1:0]     cur_phys, rd_phys, base_next, row_base_next;
    logic              rd_oob, is_nl, wrap, adv, at_bottom;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd, put_cell;

    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_cmd_ready = (r_state == ST_RUN) & out_free;
    assign cmd_take    = i_cmd_valid & o_cmd_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // logical cell -> physical cell, rows rotate on scroll
    assign cur_sum   = {1'b0, r_lin} + {1'b0, r_base};
    assign cur_wrap  = cur_sum - N_S;
    assign cur_phys  = (cur_sum >= N_S) ? cur_wrap[AW-1:0] : cur_sum[AW-1:0];
    assign rd_sum    = {1'b0, AW'(i_cmd.cell_index)} + {1'b0, r_base};
    assign rd_wrap   = rd_sum - N_S;
    assign rd_phys   = (rd_sum >= N_S) ? rd_wrap[AW-1:0] : rd_sum[AW-1:0];
    assign rd_oob    = (IW'(i_cmd.cell_index) >= N_I);
    assign base_sum  = {1'b0, r_base} + COL_S;
    assign base_next = (base_sum == N_S) ? '0 : base_sum[AW-1:0];
    assign row_base_next = r_row_base + COL_A;

    assign is_nl     = (i_cmd.op == OP_NEWLINE);
    assign wrap      = (i_cmd.op == OP_CHAR) & (r_col == LAST_COL);
    assign adv       = is_nl | wrap;
    assign at_bottom = (r_row == LAST_ROW);
    assign put_cell  = {i_text_color, i_cmd.char_code};

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_lin       = r_lin;
        n_row_base  = r_row_base;
        n_base      = r_base;
        n_clr_addr  = r_clr_addr;
        n_clr_end   = r_clr_end;
        n_rd_zero   = r_rd_zero;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wa      = r_clr_addr;
        mem_wd      = RESET_CELL;

        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_state == ST_CLEAR) begin
                    mem_wd = {i_text_color, SPACE_CODE};
                end
                if (r_clr_addr == r_clr_end) begin
                    n_state = ST_RUN;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_RUN: begin
                if (cmd_take) begin
                    if (i_cmd.op == OP_READ) begin
                        mem_re    = 1'b1;
                        n_rd_zero = rd_oob;
                        n_state   = ST_READ;
                    end else begin
                        mem_we = ~is_nl;
                        mem_wa = cur_phys;
                        mem_wd = put_cell;
                        n_out.scrolled = 1'b0;
                        if (adv) begin
                            n_col = '0;
                            if (at_bottom) begin
                                n_lin          = LAST_ROW_BASE;
                                n_base         = base_next;
                                n_clr_addr     = r_base;
                                n_clr_end      = r_base + ROW_SPAN;
                                n_state        = ST_CLEAR;
                                n_out.scrolled = 1'b1;
                            end else begin
                                n_row      = r_row + ROW_W'(1);
                                n_row_base = row_base_next;
                                n_lin      = row_base_next;
                            end
                        end else begin
                            n_col = r_col + COL_W'(1);
                            n_lin = r_lin + AW'(1);
                        end
                        n_out_valid      = 1'b1;
                        n_out.cell_data  = is_nl ? '0 : put_cell;
                        n_out.cursor_row = n_row;
                        n_out.cursor_col = n_col;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_data  = r_rd_zero ? '0 : r_rd_data;
                    n_out.cursor_row = r_row;
                    n_out.cursor_col = r_col;
                    n_out.scrolled   = 1'b0;
                    n_state          = ST_RUN;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_lin       <= '0;
            r_row_base  <= '0;
            r_base      <= '0;
            r_clr_addr  <= '0;
            r_clr_end   <= LAST_ADDR;
            r_rd_zero   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_lin       <= n_lin;
            r_row_base  <= n_row_base;
            r_base      <= n_base;
            r_clr_addr  <= n_clr_addr;
            r_clr_end   <= n_clr_end;
            r_rd_zero   <= n_rd_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_phys];
        end
    end

endmodule

[hdl/text_mode_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text-mode console with cursor, line wrap, scrolling and cell read-back.
// ----------------------------------------------------------------------------
// In the execution stage a put transaction makes at most one write to the
// single-write-port screen memory, none for a newline. A read transaction
// passes through ST_READ, as the memory read is registered. A newline, or
// a wrap, on the bottom row rotates the row ring and then fills the new
// bottom row with spaces in ST_CLEAR, during which no further command
// executes. After reset the screen memory is filled with grey spaces
// before the first command executes; input transactions are still queued
// (two deep) and text_color may be written meanwhile.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit import tmcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [CHAR_W-1:0] r_text_color;
    logic              cfg_sel;
    logic              cmd_valid, cmd_ready;
    t_cmd              cmd;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_TEXT_COLOR);
    assign prdata  = cfg_sel ? APB_DW'(r_text_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_text_color <= pwdata[CHAR_W-1:0];
        end
    end

    tmcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

[hdl/tmcw_checker.sv]
// ----------------------------------------------------------------------------
// tmcw_checker
// Port-level checks of the console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tmcw_checker import tmcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.cursor_col < COL_W'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.cursor_row < ROW_W'(ROWS))
        else $error("cursor row out of range");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scrolled |->
            o_out_item.cursor_col == '0 && o_out_item.cursor_row == ROW_W'(ROWS - 1))
        else $error("scroll left cursor off the bottom row start");

endmodule

bind text_mode_console_writer_unit tmcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
